/* rtl/ffte_pkg.sv */
// Package for the forest fire trial engine: field widths, cell and
// controller codes, register indexes and random generator constants.
// No dependencies.
`default_nettype none

package ffte_pkg;

  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int GEN_W      = 11;
  localparam int BURNT_W    = 11;
  localparam int GS_W       = 6;
  localparam int THR_W      = 17;
  localparam int SEED_W     = 32;
  localparam int DRAW_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED      = 2'd2;

  localparam logic [GS_W-1:0]   GS_RESET   = 6'd20;
  localparam logic [THR_W-1:0]  THR_RESET  = 17'd32768;
  localparam logic [THR_W-1:0]  THR_FULL   = 17'd65536;
  localparam logic [SEED_W-1:0] LFSR_RESET = 32'd1;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'h8020_0003;

  typedef enum logic [1:0] {
    CELL_UNBURNT    = 2'd0,
    CELL_SMOLDERING = 2'd1,
    CELL_BURNING    = 2'd2,
    CELL_BURNT      = 2'd3
  } cell_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_P1,
    ST_P1_TAIL,
    ST_P2_RD,
    ST_P2_CHK,
    ST_P2_NB,
    ST_P2_NW,
    ST_GEN_END,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } lfsr_ctl_t;

endpackage

`default_nettype wire

/* rtl/ffte_ifs.sv */
// Valid/ready channel interfaces of the forest fire trial engine:
// start word in, result word out. Depends on ffte_pkg.
`default_nettype none

interface ffte_in_if;
  import ffte_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] start_col;
  modport source (output valid, output start_row, output start_col, input ready);
  modport sink   (input valid, input start_row, input start_col, output ready);
endinterface

interface ffte_out_if;
  import ffte_pkg::*;
  logic               valid;
  logic               ready;
  logic [GEN_W-1:0]   generations;
  logic [BURNT_W-1:0] burnt_cells;
  modport source (output valid, output generations, output burnt_cells, input ready);
  modport sink   (input valid, input generations, input burnt_cells, output ready);
endinterface

`default_nettype wire

/* rtl/ffte_grid_mem.sv */
// Cell grid store: one write port, one read port, registered read data.
// Depends on ffte_pkg.
`default_nettype none

module ffte_grid_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ffte_pkg::cell_t   wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output ffte_pkg::cell_t   rdata
);
  import ffte_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ffte_lfsr.sv */
// 32-bit right-shifting Galois LFSR; the draw is the top half of the
// advanced value. Depends on ffte_pkg.
`default_nettype none

module ffte_lfsr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffte_pkg::lfsr_ctl_t           ctl,
  input  logic [ffte_pkg::SEED_W-1:0]   seed,
  output logic [ffte_pkg::DRAW_W-1:0]   draw
);
  import ffte_pkg::*;

  logic [SEED_W-1:0] lfsr_r;
  logic [SEED_W-1:0] lfsr_nxt;
  logic [SEED_W-1:0] stepped;

  assign stepped = {1'b0, lfsr_r[SEED_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign draw    = stepped[SEED_W-1:SEED_W-DRAW_W];

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (ctl.load) begin
      // zero would lock the register
      lfsr_nxt = (seed == '0) ? LFSR_RESET : seed;
    end else if (ctl.step) begin
      lfsr_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/forest_fire_trial_engine_top.sv */
// Forest fire trial engine, top level: sequencer, configuration registers
// and result register. Depends on ffte_pkg, ffte_ifs, ffte_grid_mem, ffte_lfsr.
//
//   channel   dir  word                          handshake
//   in_word   in   start_row, start_col          valid/ready
//   out_word  out  generations, burnt_cells      valid/ready
//   cfg_*     in   cfg_index, cfg_data           cfg_we, no wait
//
// One trial at a time. With n the used side, a trial first clears the
// n*n grid cells, then per generation runs the aging sweep, the spread
// sweep and a step to close it; for each burning cell the spread sweep
// steps through every direction, visits each in-grid neighbor and then
// resumes. Finally the result is registered. The single grid memory port
// pair sets these steps. A start cell outside the grid skips the sweeps
// and registers zeros once the result register is free. Each trial clears
// its own cells, so reset needs no clearing pass. The next start word is
// taken as soon as a result is registered; a stalled result only holds
// back the end of the following trial.
`default_nettype none

module forest_fire_trial_engine_top #(
  parameter int GRID_MAX = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ffte_in_if.sink                           in_word,
  ffte_out_if.source                        out_word,
  input  logic                              cfg_we,
  input  logic [ffte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffte_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ffte_pkg::*;

  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_MAX);
  localparam int NW    = $clog2(GRID_MAX + 1);

  function automatic cell_t age_cell(cell_t c);
    cell_t res;
    res = c;
    case (c)
      CELL_BURNING:    res = CELL_BURNT;
      CELL_SMOLDERING: res = CELL_BURNING;
      default:         res = c;
    endcase
    return res;
  endfunction

  // registers
  state_t             state_r, state_nxt;
  logic [GS_W-1:0]    gs_r, gs_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      sr_r, sr_nxt;
  logic [CW-1:0]      sc_r, sc_nxt;
  logic [AW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      r_r, r_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  dir_t               dir_r, dir_nxt;
  logic               spread_r, spread_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]      nb_addr_r, nb_addr_nxt;
  logic               smold_seen_r, smold_seen_nxt;
  logic               spread_seen_r, spread_seen_nxt;
  logic [GEN_W-1:0]   gens_r, gens_nxt;
  logic [BURNT_W-1:0] burnt_r, burnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [GEN_W-1:0]   out_gen_r, out_gen_nxt;
  logic [BURNT_W-1:0] out_burnt_r, out_burnt_nxt;

  // combinational
  cell_t              rdata;
  logic [DRAW_W-1:0]  draw;
  lfsr_ctl_t          lfsr_ctl;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  cell_t              mem_wdata;
  logic [NW-1:0]      used_n;
  logic [NW-1:0]      n_m1;
  logic               start_ok;
  logic               in_acc, out_acc, fin_go;
  logic               r_top, r_bot, c_lft, c_rgt, last_cell;
  logic [AW-1:0]      k_adv;
  logic [CW-1:0]      r_adv, c_adv;
  logic               nb_in;
  logic [AW-1:0]      nb_addr;
  logic [THR_W-1:0]   thr_eff;
  logic               nb_spread_wr;

  assign in_acc  = in_word.valid && in_word.ready;
  assign out_acc = out_valid_r && out_word.ready;
  assign fin_go  = !out_valid_r || out_word.ready;

  // clamp the used side to 2..GRID_MAX
  assign used_n = NW'((gs_r < 6'd2) ? 2 :
                      ((int'(gs_r) > GRID_MAX) ? GRID_MAX : int'(gs_r)));
  assign start_ok = (int'(in_word.start_row) < int'(used_n)) &&
                    (int'(in_word.start_col) < int'(used_n));

  assign thr_eff = (thr_r > THR_FULL) ? THR_FULL : thr_r;

  // sweep position
  assign n_m1      = NW'(n_r - 1'b1);
  assign r_top     = (r_r == '0);
  assign c_lft     = (c_r == '0);
  assign r_bot     = (NW'(r_r) == n_m1);
  assign c_rgt     = (NW'(c_r) == n_m1);
  assign last_cell = r_bot && c_rgt;
  assign c_adv     = c_rgt ? '0 : CW'(c_r + 1'b1);
  assign r_adv     = c_rgt ? (r_bot ? '0 : CW'(r_r + 1'b1)) : r_r;
  assign k_adv     = last_cell ? '0 : AW'(k_r + 1'b1);

  // neighbor of the current burning cell
  always_comb begin
    nb_in   = 1'b0;
    nb_addr = k_r;
    case (dir_r)
      DIR_N: begin
        nb_in   = !r_top;
        nb_addr = AW'(k_r - AW'(n_r));
      end
      DIR_S: begin
        nb_in   = !r_bot;
        nb_addr = AW'(k_r + AW'(n_r));
      end
      DIR_W: begin
        nb_in   = !c_lft;
        nb_addr = AW'(k_r - 1'b1);
      end
      DIR_E: begin
        nb_in   = !c_rgt;
        nb_addr = AW'(k_r + 1'b1);
      end
      default: begin
        nb_in   = 1'b0;
        nb_addr = k_r;
      end
    endcase
  end

  assign nb_spread_wr = (state_r == ST_P2_NW) && spread_r && (rdata == CELL_UNBURNT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = start_ok ? ST_CLEAR : ST_FIN;
      ST_CLEAR:   if (last_cell) state_nxt = ST_P1;
      ST_P1:      if (last_cell) state_nxt = ST_P1_TAIL;
      ST_P1_TAIL: state_nxt = ST_P2_RD;
      ST_P2_RD:   state_nxt = ST_P2_CHK;
      ST_P2_CHK: begin
        if (rdata == CELL_BURNING) begin
          state_nxt = ST_P2_NB;
        end else if (last_cell) begin
          state_nxt = ST_GEN_END;
        end
      end
      ST_P2_NB: begin
        if (nb_in) begin
          state_nxt = ST_P2_NW;
        end else if (dir_r == DIR_E) begin
          state_nxt = last_cell ? ST_GEN_END : ST_P2_RD;
        end
      end
      ST_P2_NW: begin
        if (dir_r == DIR_E) begin
          state_nxt = last_cell ? ST_GEN_END : ST_P2_RD;
        end else begin
          state_nxt = ST_P2_NB;
        end
      end
      ST_GEN_END: state_nxt = (smold_seen_r || spread_seen_r) ? ST_P1 : ST_FIN;
      ST_FIN:     if (fin_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory, generator and handshake controls
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = k_r;
    mem_wdata     = CELL_UNBURNT;
    mem_re        = 1'b0;
    mem_raddr     = k_r;
    lfsr_ctl.load = cfg_we && (cfg_index == REG_RANDOM_SEED);
    lfsr_ctl.step = 1'b0;
    in_word.ready = (state_r == ST_IDLE);
    // write back the aged cell read in the previous cycle
    if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = age_cell(rdata);
    end
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = (r_r == sr_r && c_r == sc_r) ? CELL_SMOLDERING : CELL_UNBURNT;
      end
      ST_P1: begin
        mem_re = 1'b1;
      end
      ST_P2_RD: begin
        mem_re = 1'b1;
      end
      ST_P2_CHK: begin
        if (rdata != CELL_BURNING && !last_cell) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k_r + 1'b1);
        end
      end
      ST_P2_NB: begin
        if (nb_in) begin
          lfsr_ctl.step = 1'b1;
          mem_re        = 1'b1;
          mem_raddr     = nb_addr;
        end
      end
      ST_P2_NW: begin
        if (nb_spread_wr) begin
          mem_we    = 1'b1;
          mem_waddr = nb_addr_r;
          mem_wdata = CELL_SMOLDERING;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    gs_nxt          = gs_r;
    thr_nxt         = thr_r;
    n_nxt           = n_r;
    sr_nxt          = sr_r;
    sc_nxt          = sc_r;
    k_nxt           = k_r;
    r_nxt           = r_r;
    c_nxt           = c_r;
    dir_nxt         = dir_r;
    spread_nxt      = spread_r;
    pend_nxt        = (state_r == ST_P1);
    pend_addr_nxt   = k_r;
    nb_addr_nxt     = nb_addr_r;
    smold_seen_nxt  = smold_seen_r;
    spread_seen_nxt = spread_seen_r;
    gens_nxt        = gens_r;
    burnt_nxt       = burnt_r;
    out_valid_nxt   = out_valid_r;
    out_gen_nxt     = out_gen_r;
    out_burnt_nxt   = out_burnt_r;

    if (cfg_we && cfg_index == REG_GRID_SIZE) begin
      gs_nxt = cfg_data[GS_W-1:0];
    end
    if (cfg_we && cfg_index == REG_SPREAD_THRESHOLD) begin
      thr_nxt = cfg_data[THR_W-1:0];
    end

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    // tally the aging sweep as its read data returns
    if (pend_r) begin
      if (rdata == CELL_SMOLDERING) begin
        smold_seen_nxt = 1'b1;
      end
      if (rdata == CELL_BURNING) begin
        burnt_nxt = BURNT_W'(burnt_r + 1'b1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt           = used_n;
          sr_nxt          = CW'(in_word.start_row);
          sc_nxt          = CW'(in_word.start_col);
          k_nxt           = '0;
          r_nxt           = '0;
          c_nxt           = '0;
          gens_nxt        = '0;
          burnt_nxt       = '0;
          smold_seen_nxt  = 1'b0;
          spread_seen_nxt = 1'b0;
        end
      end
      ST_CLEAR, ST_P1: begin
        k_nxt = k_adv;
        r_nxt = r_adv;
        c_nxt = c_adv;
      end
      ST_P2_CHK: begin
        if (rdata == CELL_BURNING) begin
          dir_nxt = DIR_N;
        end else begin
          k_nxt = k_adv;
          r_nxt = r_adv;
          c_nxt = c_adv;
        end
      end
      ST_P2_NB: begin
        if (nb_in) begin
          spread_nxt  = ({1'b0, draw} < thr_eff);
          nb_addr_nxt = nb_addr;
        end else if (dir_r == DIR_E) begin
          k_nxt = k_adv;
          r_nxt = r_adv;
          c_nxt = c_adv;
        end else begin
          dir_nxt = dir_t'(dir_r + 2'd1);
        end
      end
      ST_P2_NW: begin
        if (nb_spread_wr) begin
          spread_seen_nxt = 1'b1;
        end
        if (dir_r == DIR_E) begin
          k_nxt = k_adv;
          r_nxt = r_adv;
          c_nxt = c_adv;
        end else begin
          dir_nxt = dir_t'(dir_r + 2'd1);
        end
      end
      ST_GEN_END: begin
        gens_nxt        = GEN_W'(gens_r + 1'b1);
        smold_seen_nxt  = 1'b0;
        spread_seen_nxt = 1'b0;
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_gen_nxt   = gens_r;
          out_burnt_nxt = burnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gs_r        <= GS_RESET;
      thr_r       <= THR_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      thr_r       <= thr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and sweep registers
  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    sr_r          <= sr_nxt;
    sc_r          <= sc_nxt;
    k_r           <= k_nxt;
    r_r           <= r_nxt;
    c_r           <= c_nxt;
    dir_r         <= dir_nxt;
    spread_r      <= spread_nxt;
    pend_addr_r   <= pend_addr_nxt;
    nb_addr_r     <= nb_addr_nxt;
    smold_seen_r  <= smold_seen_nxt;
    spread_seen_r <= spread_seen_nxt;
    gens_r        <= gens_nxt;
    burnt_r       <= burnt_nxt;
    out_gen_r     <= out_gen_nxt;
    out_burnt_r   <= out_burnt_nxt;
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.generations = out_gen_r;
  assign out_word.burnt_cells = out_burnt_r;

  ffte_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  ffte_lfsr u_lfsr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lfsr_ctl),
    .seed  (cfg_data[SEED_W-1:0]),
    .draw  (draw)
  );

endmodule

`default_nettype wire
